// ===== sv/assert_macros.svh =====
// Assertion macros shared by the haar feature evaluator RTL.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define HFE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: assertion failed");

// Check that a condition never holds outside reset.
`define HFE_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("%m: forbidden condition seen");

`else

`define HFE_ASSERT(lbl, clk, rstn, prop)
`define HFE_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ===== sv/hfe_pkg.sv =====
// Shared widths, codes, types and the pattern weight table of the
// haar feature evaluator. No dependencies.
package hfe_pkg;

  localparam int WINDOW          = 24;
  localparam int CORNERS         = 4;
  localparam int SLOTS           = CORNERS * CORNERS;
  localparam int SLOT_W          = $clog2(SLOTS);
  localparam int IDX_W           = 5;
  localparam int VALUE_W         = 18;
  localparam int NORM_W          = 16;
  localparam int FTYPE_W         = 3;
  localparam int CORNER_PACK_W   = IDX_W * CORNERS;
  localparam int CFG_DATA_W      = 20;
  localparam int CFG_IDX_W       = 2;
  localparam int SUM_W           = 22;
  localparam int ACC_W           = 24;
  localparam int FEAT_W          = 32;
  localparam int WEIGHT_W        = 4;
  localparam int FRAC_SHIFT      = 16;
  localparam int DIVIDEND_W      = SUM_W + FRAC_SHIFT;
  localparam int DIV_CNT_W       = $clog2(DIVIDEND_W + 1);
  localparam int QUEUE_DEPTH_DEF = 2;

  // input command codes
  localparam logic CMD_ENTRY = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FEATURE_TYPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_CORNERS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COL_CORNERS  = 2'd2;

  // feature patterns
  localparam logic [FTYPE_W-1:0] FT_TWO_ROWS   = 3'd0;
  localparam logic [FTYPE_W-1:0] FT_TWO_COLS   = 3'd1;
  localparam logic [FTYPE_W-1:0] FT_THREE_ROWS = 3'd2;
  localparam logic [FTYPE_W-1:0] FT_THREE_COLS = 3'd3;
  localparam logic [FTYPE_W-1:0] FT_FOUR       = 3'd4;

  typedef struct packed {
    logic [NORM_W-1:0]               normalizer;
    logic [SLOTS-1:0][VALUE_W-1:0]   corners;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Weight of corner slot (row*4 + col) for a pattern; slot 0 in the low nibble.
  function automatic logic signed [WEIGHT_W-1:0] pattern_weight(
    input logic [FTYPE_W-1:0] ftype,
    input logic [SLOT_W-1:0]  slot
  );
    logic [SLOTS*WEIGHT_W-1:0] row;
    case (ftype)
      FT_TWO_ROWS:   row = 64'h0000_010F_0E02_010F;
      FT_TWO_COLS:   row = 64'h0000_01E1_0000_0F2F;
      FT_THREE_ROWS: row = 64'h010F_0D03_030D_0F01;
      FT_THREE_COLS: row = 64'h0000_1D3F_0000_F3D1;
      FT_FOUR:       row = 64'h0000_01E1_0E4E_01E1;
      default:       row = '0;
    endcase
    return row[slot*WEIGHT_W +: WEIGHT_W];
  endfunction

endpackage

// ===== sv/hfe_if.sv =====
// Valid/ready channel interfaces of the haar feature evaluator.
// Depends on hfe_pkg for payload widths.
interface hfe_in_if;
  import hfe_pkg::*;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [IDX_W-1:0]   row;
  logic [IDX_W-1:0]   col;
  logic [VALUE_W-1:0] value;
  logic [NORM_W-1:0]  normalizer;

  modport source (output valid, cmd, row, col, value, normalizer, input ready);
  modport sink   (input valid, cmd, row, col, value, normalizer, output ready);
endinterface

interface hfe_out_if;
  import hfe_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [SUM_W-1:0]  raw_sum;
  logic signed [FEAT_W-1:0] feature_value;
  logic                     zero_divide;

  modport source (output valid, raw_sum, feature_value, zero_divide, input ready);
  modport sink   (input valid, raw_sum, feature_value, zero_divide, output ready);
endinterface

// ===== sv/hfe_front.sv =====
// Front end: configuration registers, corner capture and word classification.
// Depends on hfe_pkg and hfe_in_if.
module hfe_front (
  input  logic                             clk,
  input  logic                             rst_n,
  hfe_in_if.sink                           in_ch,
  input  logic                             cfg_we,
  input  logic [hfe_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [hfe_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  hfe_pkg::q_stat_t                 q_stat_i,
  output logic                             q_push_o,
  output hfe_pkg::qent_t                   q_entry_o,
  output logic [hfe_pkg::FTYPE_W-1:0]      feature_type_o
);
  import hfe_pkg::*;

  logic [FTYPE_W-1:0]            feature_type_r;
  logic [CORNER_PACK_W-1:0]      row_corners_r;
  logic [CORNER_PACK_W-1:0]      col_corners_r;
  logic [SLOTS-1:0][VALUE_W-1:0] store_r;

  logic             accept;
  logic             in_win;
  logic [SLOTS-1:0] hit;

  assign in_ch.ready = !q_stat_i.full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    in_win = (in_ch.row <= IDX_W'(WINDOW)) && (in_ch.col <= IDX_W'(WINDOW));
    for (int i = 0; i < CORNERS; i++) begin
      for (int j = 0; j < CORNERS; j++) begin
        // a repeated corner index writes every matching slot
        hit[i*CORNERS + j] = accept && (in_ch.cmd == CMD_ENTRY) && in_win &&
                             (row_corners_r[i*IDX_W +: IDX_W] == in_ch.row) &&
                             (col_corners_r[j*IDX_W +: IDX_W] == in_ch.col);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feature_type_r <= '0;
      row_corners_r  <= '0;
      col_corners_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_FEATURE_TYPE: feature_type_r <= cfg_data[FTYPE_W-1:0];
        REG_ROW_CORNERS:  row_corners_r  <= cfg_data[CORNER_PACK_W-1:0];
        REG_COL_CORNERS:  col_corners_r  <= cfg_data[CORNER_PACK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < SLOTS; s++) begin
      if (hit[s]) begin
        store_r[s] <= in_ch.value;
      end
    end
  end

  // evaluation word: snapshot the corners so capture can run on
  assign q_push_o             = accept && (in_ch.cmd == CMD_EVAL);
  assign q_entry_o.normalizer = in_ch.normalizer;
  assign q_entry_o.corners    = store_r;
  assign feature_type_o       = feature_type_r;

endmodule

// ===== sv/hfe_queue.sv =====
// Short queue of evaluation requests between front and back.
// Depends on hfe_pkg and assert_macros.svh.
module hfe_queue #(
  parameter int DEPTH = hfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  hfe_pkg::qent_t   push_data_i,
  input  logic             pop_i,
  output hfe_pkg::qent_t   head_o,
  output hfe_pkg::q_stat_t stat_o
);
  import hfe_pkg::*;
  `include "assert_macros.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  qent_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push_i ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop_i  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_data_i;
    end
  end

  assign head_o       = mem_r[rd_ptr_r];
  assign stat_o.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_r == '0);

  `HFE_ASSERT_NEVER(a_no_overflow, clk, rst_n, push_i && stat_o.full)
  `HFE_ASSERT_NEVER(a_no_underflow, clk, rst_n, pop_i && stat_o.empty)
  `HFE_ASSERT(a_cnt_up, clk, rst_n, (push_i && !pop_i) |=> (cnt_r == $past(cnt_r) + 1'b1))

endmodule

// ===== sv/hfe_back.sv =====
// Back end: weighted corner sum, saturation, restoring divide, output register.
// Depends on hfe_pkg, hfe_out_if and assert_macros.svh.
module hfe_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hfe_pkg::qent_t              head_i,
  input  hfe_pkg::q_stat_t            q_stat_i,
  output logic                        q_pop_o,
  input  logic [hfe_pkg::FTYPE_W-1:0] feature_type_i,
  hfe_out_if.source                   out_ch
);
  import hfe_pkg::*;
  `include "assert_macros.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ACC  = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'((2 ** (SUM_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] ACC_LO = ~ACC_HI;
  localparam logic [FEAT_W-1:0] FEAT_MAX = {1'b0, {(FEAT_W-1){1'b1}}};
  localparam logic [FEAT_W-1:0] FEAT_MIN = {1'b1, {(FEAT_W-1){1'b0}}};
  localparam logic [DIVIDEND_W-1:0] POS_LIM = {{(DIVIDEND_W-FEAT_W){1'b0}}, FEAT_MAX};
  localparam logic [DIVIDEND_W-1:0] NEG_LIM = {{(DIVIDEND_W-FEAT_W){1'b0}}, FEAT_MIN};

  logic [2:0]              state_r, state_nxt;
  logic [SLOT_W-1:0]       k_r, k_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [NORM_W-1:0]       norm_r, norm_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic                    neg_r, neg_nxt;
  logic                    zero_r, zero_nxt;
  logic [NORM_W-1:0]       rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0]   dvd_r, dvd_nxt;
  logic [DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]        out_sum_r, out_sum_nxt;
  logic [FEAT_W-1:0]       out_feat_r, out_feat_nxt;
  logic                    out_zdiv_r, out_zdiv_nxt;

  logic signed [WEIGHT_W-1:0] weight;
  logic signed [VALUE_W+WEIGHT_W:0] term;
  logic [SUM_W-1:0]  sum_sat;
  logic [SUM_W-1:0]  mag;
  logic [NORM_W:0]   shifted;
  logic              ge;
  logic [FEAT_W-1:0] quot;

  always_comb begin
    weight  = pattern_weight(feature_type_i, k_r);
    term    = $signed({1'b0, head_i.corners[k_r]}) * weight;

    if (acc_r > ACC_HI) begin
      sum_sat = ACC_HI[SUM_W-1:0];
    end else if (acc_r < ACC_LO) begin
      sum_sat = ACC_LO[SUM_W-1:0];
    end else begin
      sum_sat = acc_r[SUM_W-1:0];
    end
    mag = sum_sat[SUM_W-1] ? (~sum_sat + 1'b1) : sum_sat;

    shifted = {rem_r, dvd_r[DIVIDEND_W-1]};
    ge      = (shifted >= {1'b0, norm_r});

    // final value: zero divide first, then saturate the magnitude
    if (zero_r) begin
      quot = (sum_r == '0) ? '0 : (neg_r ? FEAT_MIN : FEAT_MAX);
    end else if (neg_r) begin
      quot = (dvd_r > NEG_LIM) ? FEAT_MIN : (~dvd_r[FEAT_W-1:0] + 1'b1);
    end else begin
      quot = (dvd_r > POS_LIM) ? FEAT_MAX : dvd_r[FEAT_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    norm_nxt      = norm_r;
    sum_nxt       = sum_r;
    neg_nxt       = neg_r;
    zero_nxt      = zero_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_sum_nxt   = out_sum_r;
    out_feat_nxt  = out_feat_r;
    out_zdiv_nxt  = out_zdiv_r;
    q_pop_o       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          k_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        acc_nxt = acc_r + {{(ACC_W-VALUE_W-WEIGHT_W-1){term[VALUE_W+WEIGHT_W]}}, term};
        k_nxt   = k_r + 1'b1;
        if (k_r == SLOT_W'(SLOTS - 1)) begin
          // last corner: release the queue slot, keep the normalizer
          q_pop_o   = 1'b1;
          norm_nxt  = head_i.normalizer;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        sum_nxt  = sum_sat;
        neg_nxt  = sum_sat[SUM_W-1];
        zero_nxt = (norm_r == '0);
        rem_nxt  = '0;
        dvd_nxt  = {mag, {FRAC_SHIFT{1'b0}}};
        cnt_nxt  = '0;
        state_nxt = (norm_r == '0) ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = ge ? (shifted[NORM_W-1:0] - norm_r) : shifted[NORM_W-1:0];
        dvd_nxt = {dvd_r[DIVIDEND_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIVIDEND_W - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register frees up
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = sum_r;
          out_feat_nxt  = quot;
          out_zdiv_nxt  = zero_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    acc_r      <= acc_nxt;
    norm_r     <= norm_nxt;
    sum_r      <= sum_nxt;
    neg_r      <= neg_nxt;
    zero_r     <= zero_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    cnt_r      <= cnt_nxt;
    out_sum_r  <= out_sum_nxt;
    out_feat_r <= out_feat_nxt;
    out_zdiv_r <= out_zdiv_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.raw_sum       = out_sum_r;
  assign out_ch.feature_value = out_feat_r;
  assign out_ch.zero_divide   = out_zdiv_r;

  `HFE_ASSERT(a_div_count, clk, rst_n, (state_r == ST_DIV) |-> (cnt_r < DIV_CNT_W'(DIVIDEND_W)))
  `HFE_ASSERT(a_zdiv_value, clk, rst_n, (out_valid_r && out_zdiv_r) |-> ((out_sum_r == '0 && out_feat_r == '0) || (!out_sum_r[SUM_W-1] && out_sum_r != '0 && out_feat_r == FEAT_MAX) || (out_sum_r[SUM_W-1] && out_feat_r == FEAT_MIN)))
  `HFE_ASSERT(a_sign, clk, rst_n, (out_valid_r && out_feat_r != '0) |-> (out_feat_r[FEAT_W-1] == out_sum_r[SUM_W-1]))

endmodule

// ===== sv/haar_feature_evaluate.sv =====
// Top level of the haar feature evaluator: front, request queue and back.
// Depends on hfe_pkg, hfe_in_if, hfe_out_if, hfe_front, hfe_queue, hfe_back.
//
//   channel   dir   handshake        payload
//   in_ch     in    valid / ready    cmd, row, col, value, normalizer
//   out_ch    out   valid / ready    raw_sum, feature_value, zero_divide
//   cfg_*     in    cfg_we           cfg_idx, cfg_data
//
// Entry words are taken one per cycle while the request queue has room.
// An evaluate word passes through the back end as 1 start step, 16 corner
// accumulate steps, 1 saturate step, 38 restoring divide steps and 1 output
// load; the divide steps are skipped when the normalizer is zero. The divider
// is one-bit-per-cycle.
// The queue holds QUEUE_DEPTH evaluations, so capture of the next sample goes
// on meanwhile; a result held on out_ch stalls the back end, and in_ch too once the queue fills.
// Reset is synchronous active low; the corner store is not cleared.
module haar_feature_evaluate #(
  parameter int QUEUE_DEPTH = hfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  hfe_in_if.sink                         in_ch,
  hfe_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [hfe_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [hfe_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hfe_pkg::*;

  logic               q_push;
  logic               q_pop;
  qent_t              q_entry;
  qent_t              q_head;
  q_stat_t            q_stat;
  logic [FTYPE_W-1:0] feature_type;

  hfe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .q_stat_i       (q_stat),
    .q_push_o       (q_push),
    .q_entry_o      (q_entry),
    .feature_type_o (feature_type)
  );

  hfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (q_push),
    .push_data_i (q_entry),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .stat_o      (q_stat)
  );

  hfe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_i         (q_head),
    .q_stat_i       (q_stat),
    .q_pop_o        (q_pop),
    .feature_type_i (feature_type),
    .out_ch         (out_ch)
  );

endmodule

// ===== bench/tb_haar_feature_evaluate.sv =====
`timescale 1ns / 1ps
// Testbench for haar_feature_evaluate: directed table, then random sample windows.
// Depends on hfe_pkg, hfe_in_if, hfe_out_if and the haar_feature_evaluate RTL.
module tb_haar_feature_evaluate;
  import hfe_pkg::*;

  typedef enum logic {STEP_CFG, STEP_WORD} step_kind_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]  raw_sum;
    logic signed [FEAT_W-1:0] feature_value;
    logic                     zero_divide;
  } feat_result_t;

  typedef struct {
    step_kind_t             kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  data;
    logic                   cmd;
    logic [IDX_W-1:0]       row;
    logic [IDX_W-1:0]       col;
    logic [VALUE_W-1:0]     value;
    logic [NORM_W-1:0]      norm;
    bit                     typed;
    feat_result_t           want;
  } script_step_t;

  localparam logic [FTYPE_W-1:0]       FT_UNKNOWN    = 3'd7;
  localparam logic [VALUE_W-1:0]       VALUE_MAX     = 18'd146880;
  localparam logic [CORNER_PACK_W-1:0] GRID_8        = 20'hC4100; // corners 0, 8, 16, 24
  localparam logic [CORNER_PACK_W-1:0] PACK_ALL_31   = 20'hFFFFF;
  localparam int                       N_WORDS       = 1300;
  localparam int                       SETTLE_CYCLES = 64;
  localparam longint                   SUM_HI        = 2097151;
  localparam longint                   SUM_LO        = -2097152;
  localparam longint                   FEAT_HI       = 2147483647;
  localparam longint                   FEAT_LO       = -64'sd2147483648;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  hfe_in_if  in_ch ();
  hfe_out_if out_ch ();

  haar_feature_evaluate uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // feature model state
  logic [FTYPE_W-1:0]       ft_q;
  logic [CORNER_PACK_W-1:0] rows_q;
  logic [CORNER_PACK_W-1:0] cols_q;
  logic [VALUE_W-1:0]       corner_val [SLOTS];
  bit   [SLOTS-1:0]         corner_seen;

  feat_result_t pending_features [$];
  script_step_t script [$];
  bit           calm;
  int           words_sent;
  int           failures;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_haar_feature_evaluate failed");
    $finish;
  end

  function automatic int corner_gain(logic [FTYPE_W-1:0] ft, int slot);
    int g [SLOTS];
    case (ft)
      FT_TWO_ROWS:   g = '{-1, 0, 1, 0, 2, 0, -2, 0, -1, 0, 1, 0, 0, 0, 0, 0};
      FT_TWO_COLS:   g = '{-1, 2, -1, 0, 0, 0, 0, 0, 1, -2, 1, 0, 0, 0, 0, 0};
      FT_THREE_ROWS: g = '{1, 0, -1, 0, -3, 0, 3, 0, 3, 0, -3, 0, -1, 0, 1, 0};
      FT_THREE_COLS: g = '{1, -3, 3, -1, 0, 0, 0, 0, -1, 3, -3, 1, 0, 0, 0, 0};
      FT_FOUR:       g = '{1, -2, 1, 0, -2, 4, -2, 0, 1, -2, 1, 0, 0, 0, 0, 0};
      default:       g = '{default: 0};
    endcase
    return g[slot];
  endfunction

  function automatic feat_result_t compute_feature(logic [NORM_W-1:0] norm);
    longint       s;
    longint       q;
    feat_result_t r;
    s = 0;
    for (int k = 0; k < SLOTS; k++)
      s += longint'(corner_gain(ft_q, k)) * longint'(corner_val[k]);
    if (s > SUM_HI) s = SUM_HI;
    if (s < SUM_LO) s = SUM_LO;
    if (norm == '0) begin
      q = (s > 0) ? FEAT_HI : (s < 0) ? FEAT_LO : 0;
    end else begin
      q = (s * 65536) / longint'(norm);
      if (q > FEAT_HI) q = FEAT_HI;
      if (q < FEAT_LO) q = FEAT_LO;
    end
    r.raw_sum       = s[SUM_W-1:0];
    r.feature_value = q[FEAT_W-1:0];
    r.zero_divide   = (norm == '0);
    return r;
  endfunction

  // Write every slot whose row and column corner both match; drop out-of-window entries.
  function automatic void store_entry(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                                      logic [VALUE_W-1:0] v);
    if (r > WINDOW || c > WINDOW) return;
    for (int i = 0; i < CORNERS; i++)
      for (int j = 0; j < CORNERS; j++)
        if (rows_q[IDX_W*i +: IDX_W] == r && cols_q[IDX_W*j +: IDX_W] == c) begin
          corner_val[i*CORNERS + j]  = v;
          corner_seen[i*CORNERS + j] = 1'b1;
        end
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return VALUE_MAX;
      default: return VALUE_W'($urandom_range(0, VALUE_MAX));
    endcase
  endfunction

  function automatic logic [CORNER_PACK_W-1:0] pick_corners();
    logic [CORNER_PACK_W-1:0] p;
    logic [IDX_W-1:0]         same;
    same = IDX_W'($urandom_range(0, WINDOW));
    case ($urandom_range(0, 9))
      6:       p = {CORNERS{same}};
      7:       p = '0;
      8:       p = PACK_ALL_31;
      9:       p = CORNER_PACK_W'($urandom);
      default: for (int k = 0; k < CORNERS; k++)
                 p[IDX_W*k +: IDX_W] = IDX_W'($urandom_range(0, WINDOW));
    endcase
    return p;
  endfunction

  function automatic script_step_t cfg_step(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] data);
    script_step_t s;
    s = '{kind: STEP_CFG, reg_idx: idx, data: data, typed: 1'b0, want: '0, default: '0};
    return s;
  endfunction

  function automatic script_step_t entry_step(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                                              logic [VALUE_W-1:0] v);
    script_step_t s;
    s = '{kind: STEP_WORD, cmd: CMD_ENTRY, row: r, col: c, value: v, typed: 1'b0,
          want: '0, default: '0};
    return s;
  endfunction

  function automatic script_step_t eval_step(logic [NORM_W-1:0] n, bit typed,
                                             feat_result_t want);
    script_step_t s;
    s = '{kind: STEP_WORD, cmd: CMD_EVAL, norm: n, typed: typed, want: want, default: '0};
    return s;
  endfunction

  task automatic send_word(logic cmd, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                           logic [VALUE_W-1:0] v, logic [NORM_W-1:0] n,
                           bit typed, feat_result_t want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.row        <= r;
    in_ch.col        <= c;
    in_ch.value      <= v;
    in_ch.normalizer <= n;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    if (cmd == CMD_EVAL)
      pending_features.push_back(typed ? want : compute_feature(n));
    else
      store_entry(r, c, v);
  endtask

  // Hold the sender until all results are back and entries have drained.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_features.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_FEATURE_TYPE: ft_q   = data[FTYPE_W-1:0];
      REG_ROW_CORNERS:  rows_q = data[CORNER_PACK_W-1:0];
      REG_COL_CORNERS:  cols_q = data[CORNER_PACK_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // result checker
  initial begin
    int           stall;
    feat_result_t want;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if (pending_features.size() == 0) begin
        $display("%0t: unexpected word: raw_sum %0d feature_value %0d zero_divide %0b",
                 $time, out_ch.raw_sum, out_ch.feature_value, out_ch.zero_divide);
        failures++;
      end else begin
        want = pending_features.pop_front();
        if (out_ch.raw_sum !== want.raw_sum) begin
          $display("%0t: raw_sum expected %0d actual %0d", $time, want.raw_sum, out_ch.raw_sum);
          failures++;
        end
        if (out_ch.feature_value !== want.feature_value) begin
          $display("%0t: feature_value expected %0d actual %0d", $time,
                   want.feature_value, out_ch.feature_value);
          failures++;
        end
        if (out_ch.zero_divide !== want.zero_divide) begin
          $display("%0t: zero_divide expected %0b actual %0b", $time,
                   want.zero_divide, out_ch.zero_divide);
          failures++;
        end
      end
    end
  end

  initial begin
    int                  order [SLOTS];
    int                  pick;
    int                  tmp;
    int                  n_samples;
    bit                  broken;
    logic [NORM_W-1:0]   norm;
    logic [FTYPE_W-1:0]  ft_pick;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= REG_FEATURE_TYPE;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_ENTRY;
    in_ch.row        <= '0;
    in_ch.col        <= '0;
    in_ch.value      <= '0;
    in_ch.normalizer <= '0;
    calm        = 1'b0;
    words_sent  = 0;
    failures    = 0;
    ft_q        = FT_TWO_ROWS;
    rows_q      = '0;
    cols_q      = '0;
    corner_seen = '0;
    foreach (corner_val[k]) corner_val[k] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // All corners sit at index 0 after reset, so one entry fills the whole store.
    script.push_back(entry_step(0, 0, VALUE_MAX));
    script.push_back(eval_step(0, 1'b1, '{raw_sum: 0, feature_value: 0, zero_divide: 1'b1}));
    script.push_back(eval_step(16'hFFFF, 1'b1, '{raw_sum: 0, feature_value: 0,
                                                  zero_divide: 1'b0}));
    script.push_back(cfg_step(REG_FEATURE_TYPE, CFG_DATA_W'(FT_FOUR)));
    script.push_back(cfg_step(REG_ROW_CORNERS, GRID_8));
    script.push_back(cfg_step(REG_COL_CORNERS, GRID_8));
    script.push_back(entry_step(8, 8, 0));
    script.push_back(eval_step(0, 1'b1, '{raw_sum: -587520, feature_value: 32'sh8000_0000,
                                          zero_divide: 1'b1}));
    script.push_back(entry_step(8, 8, VALUE_MAX));
    script.push_back(entry_step(0, 0, 0));
    script.push_back(eval_step(1, 1'b1, '{raw_sum: -146880, feature_value: 32'sh8000_0000,
                                          zero_divide: 1'b0}));
    script.push_back(entry_step(0, 0, VALUE_MAX));
    script.push_back(entry_step(0, 8, 0));
    script.push_back(eval_step(0, 1'b1, '{raw_sum: 293760, feature_value: 32'sh7FFF_FFFF,
                                          zero_divide: 1'b1}));
    script.push_back(eval_step(16'hFFFF, 1'b0, '0));
    script.push_back(entry_step(31, 31, 7));
    script.push_back(entry_step(24, 25, 9));
    script.push_back(eval_step(16'd256, 1'b0, '0));
    // Corners beyond the window: entries must leave the store alone.
    script.push_back(cfg_step(REG_ROW_CORNERS, PACK_ALL_31));
    script.push_back(cfg_step(REG_COL_CORNERS, PACK_ALL_31));
    script.push_back(entry_step(31, 31, 0));
    script.push_back(eval_step(16'd256, 1'b0, '0));
    script.push_back(cfg_step(REG_FEATURE_TYPE, CFG_DATA_W'(FT_UNKNOWN)));
    script.push_back(eval_step(16'd256, 1'b1, '{raw_sum: 0, feature_value: 0,
                                                 zero_divide: 1'b0}));
    script.push_back(cfg_step(REG_FEATURE_TYPE, CFG_DATA_W'(FT_TWO_COLS)));
    script.push_back(eval_step(16'd4096, 1'b0, '0));
    script.push_back(cfg_step(REG_FEATURE_TYPE, CFG_DATA_W'(FT_THREE_ROWS)));
    script.push_back(eval_step(16'd3, 1'b0, '0));
    script.push_back(cfg_step(REG_FEATURE_TYPE, CFG_DATA_W'(FT_THREE_COLS)));
    script.push_back(eval_step(16'd777, 1'b0, '0));
    script.push_back(cfg_step(REG_FEATURE_TYPE, CFG_DATA_W'(FT_TWO_ROWS)));
    script.push_back(eval_step(16'h8000, 1'b0, '0));

    foreach (script[i]) begin
      if (script[i].kind == STEP_CFG) begin
        settle();
        write_reg(script[i].reg_idx, script[i].data);
      end else begin
        send_word(script[i].cmd, script[i].row, script[i].col, script[i].value,
                  script[i].norm, script[i].typed, script[i].want);
      end
    end

    while (words_sent < N_WORDS) begin
      settle();
      calm    = ($urandom_range(0, 3) == 0);
      ft_pick = ($urandom_range(0, 7) == 0) ? FTYPE_W'($urandom_range(5, 7)) :
                                              FTYPE_W'($urandom_range(0, 4));
      write_reg(REG_FEATURE_TYPE, CFG_DATA_W'(ft_pick));
      write_reg(REG_ROW_CORNERS, pick_corners());
      write_reg(REG_COL_CORNERS, pick_corners());
      n_samples = $urandom_range(2, 6);
      repeat (n_samples) begin
        broken = ($urandom_range(0, 6) == 0);
        for (int k = 0; k < SLOTS; k++) order[k] = k;
        for (int k = SLOTS - 1; k > 0; k--) begin
          pick        = $urandom_range(0, k);
          tmp         = order[k];
          order[k]    = order[pick];
          order[pick] = tmp;
        end
        foreach (order[k]) begin
          if ($urandom_range(0, 9) == 0)
            send_word(CMD_ENTRY, IDX_W'($urandom_range(0, 31)), IDX_W'($urandom_range(0, 31)),
                      pick_value(), NORM_W'($urandom), 1'b0, '0);
          if (!broken || $urandom_range(0, 1) == 1)
            send_word(CMD_ENTRY, rows_q[IDX_W*(order[k]/CORNERS) +: IDX_W],
                      cols_q[IDX_W*(order[k]%CORNERS) +: IDX_W], pick_value(),
                      NORM_W'($urandom), 1'b0, '0);
        end
        case ($urandom_range(0, 9))
          0:       norm = '0;
          1:       norm = NORM_W'($urandom_range(1, 255));
          2:       norm = 16'hFFFF;
          default: norm = NORM_W'($urandom);
        endcase
        // Never evaluate while a store slot is still unwritten.
        if (&corner_seen)
          send_word(CMD_EVAL, IDX_W'($urandom), IDX_W'($urandom), VALUE_W'($urandom), norm,
                    1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_features.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("tb_haar_feature_evaluate passed");
    else
      $display("tb_haar_feature_evaluate failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/hfe_pkg.sv
sv/hfe_if.sv
sv/hfe_front.sv
sv/hfe_queue.sv
sv/hfe_back.sv
sv/haar_feature_evaluate.sv
bench/tb_haar_feature_evaluate.sv
